FILE: hdl/u8d_pkg.sv
package u8d_pkg;

  // Byte classes and limits of the UTF-8 rules.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_MIN = 8'hc2;
  localparam logic [7:0] LEAD_MAX = 8'hf4;
  localparam logic [7:0] LEAD_THREE = 8'he0;
  localparam logic [7:0] LEAD_FOUR = 8'hf0;
  localparam logic [7:0] LEAD_SURROGATE = 8'hed;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG = 8'h80;

  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] SURROGATE_BASE = 21'h00d800;
  localparam logic [20:0] MIN_FOUR = 21'h010000;
  localparam logic [20:0] MAX_SCALAR = 21'h10ffff;

  localparam logic [2:0] LEN_ONE = 3'd1;
  localparam logic [2:0] LEN_TWO = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_length;
    logic        decode_error;
    logic        at_buffer_end;
  } out_t;

  // Outcome of one decode step: whether a result is produced, and the result.
  typedef struct packed {
    logic emit;
    out_t item;
  } step_t;

endpackage

FILE: hdl/utf8_validating_decoder.sv
// UTF-8 validating decoder. Bytes of a buffer arrive one per request on the
// input channel, with buffer_last marking the final byte of each buffer. Each
// completed code point yields one result holding the scalar value and its
// length of one to four bytes; continuation bytes in the middle of a sequence
// yield none. Malformed input (a bad lead byte, a missing continuation byte,
// a sequence cut short by the end of the buffer, a surrogate, an overlong
// three-byte form or a four-byte value outside 0x10000..0x10FFFF) yields one
// error result with code_point and seq_length at zero, after which the
// remaining bytes of that buffer are dropped without results; the next buffer
// starts clean. The block sustains one byte per clock while the output side
// keeps up: a byte is captured in an input register and decoded from there
// into the result register, which presents its result to the output side.
// Throughput is set by the single decode step that updates the sequence state
// once per byte; it drops only while a result waits in the result register
// and the output side stalls.
module utf8_validating_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  u8d_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output u8d_pkg::out_t out_data
);

  // Input register stage.
  logic         stage_valid;
  u8d_pkg::in_t stage_data;

  u8d_pkg::step_t step;
  logic           advance;
  logic           out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // The staged byte is decoded when its result, if any, has somewhere to go.
  assign advance = stage_valid && (out_free || !step.emit);

  assign in_ready = !stage_valid || advance;

  u8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_data),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && step.emit) begin
      out_data <= step.item;
    end
  end

endmodule

FILE: hdl/u8d_decode.sv
module u8d_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  u8d_pkg::in_t  item,
  output u8d_pkg::step_t step
);

  logic [7:0]  lead_value;
  logic [20:0] bits_gathered;
  logic [1:0]  bytes_remaining;
  logic [2:0]  seq_total;
  logic        faulted;

  logic [7:0]  lead_value_next;
  logic [20:0] bits_gathered_next;
  logic [1:0]  bytes_remaining_next;
  logic [2:0]  seq_total_next;
  logic        faulted_next;

  logic [7:0]  b;
  logic        last;
  logic        do_fail;
  logic        go_idle;
  logic [20:0] gathered;
  logic [1:0]  remaining_dec;
  logic        bad_value;

  assign b = item.data_byte;
  assign last = item.buffer_last;
  assign gathered = {bits_gathered[14:0], b[5:0]};
  assign remaining_dec = bytes_remaining - 2'd1;

  always_comb begin
    bad_value = 1'b0;
    if (seq_total == u8d_pkg::LEN_THREE) begin
      if (gathered < u8d_pkg::MIN_THREE) bad_value = 1'b1;
      if (lead_value == u8d_pkg::LEAD_SURROGATE && gathered >= u8d_pkg::SURROGATE_BASE)
        bad_value = 1'b1;
    end else if (seq_total == u8d_pkg::LEN_FOUR) begin
      if (gathered < u8d_pkg::MIN_FOUR || gathered > u8d_pkg::MAX_SCALAR) bad_value = 1'b1;
    end
  end

  always_comb begin
    lead_value_next = lead_value;
    bits_gathered_next = bits_gathered;
    bytes_remaining_next = bytes_remaining;
    seq_total_next = seq_total;
    faulted_next = faulted;
    do_fail = 1'b0;
    go_idle = 1'b0;
    step = '0;
    step.item.at_buffer_end = last;

    if (faulted) begin
      // Discarding after an error; the buffer's last byte ends it silently.
      if (last) begin
        faulted_next = 1'b0;
        go_idle = 1'b1;
      end
    end else if (bytes_remaining == 2'd0) begin
      if (b < u8d_pkg::ASCII_LIMIT) begin
        step.emit = 1'b1;
        step.item.code_point = {13'd0, b};
        step.item.seq_length = u8d_pkg::LEN_ONE;
      end else if (!(b inside {[u8d_pkg::LEAD_MIN:u8d_pkg::LEAD_MAX]})) begin
        do_fail = 1'b1;
      end else begin
        lead_value_next = b;
        if (b < u8d_pkg::LEAD_THREE) begin
          seq_total_next = u8d_pkg::LEN_TWO;
          bytes_remaining_next = 2'd1;
          bits_gathered_next = {16'd0, b[4:0]};
        end else if (b < u8d_pkg::LEAD_FOUR) begin
          seq_total_next = u8d_pkg::LEN_THREE;
          bytes_remaining_next = 2'd2;
          bits_gathered_next = {17'd0, b[3:0]};
        end else begin
          seq_total_next = u8d_pkg::LEN_FOUR;
          bytes_remaining_next = 2'd3;
          bits_gathered_next = {18'd0, b[2:0]};
        end
        if (last) do_fail = 1'b1;
      end
    end else if ((b & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_TAG) begin
      do_fail = 1'b1;
    end else if (remaining_dec != 2'd0) begin
      bits_gathered_next = gathered;
      bytes_remaining_next = remaining_dec;
      if (last) do_fail = 1'b1;
    end else if (bad_value) begin
      do_fail = 1'b1;
    end else begin
      go_idle = 1'b1;
      step.emit = 1'b1;
      step.item.code_point = gathered;
      step.item.seq_length = seq_total;
    end

    if (do_fail) begin
      go_idle = 1'b1;
      faulted_next = !last;
      step.emit = 1'b1;
      step.item.code_point = '0;
      step.item.seq_length = '0;
      step.item.decode_error = 1'b1;
    end

    if (go_idle) begin
      lead_value_next = '0;
      bits_gathered_next = '0;
      bytes_remaining_next = '0;
      seq_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_value <= '0;
      bits_gathered <= '0;
      bytes_remaining <= '0;
      seq_total <= '0;
      faulted <= 1'b0;
    end else if (advance) begin
      lead_value <= lead_value_next;
      bits_gathered <= bits_gathered_next;
      bytes_remaining <= bytes_remaining_next;
      seq_total <= seq_total_next;
      faulted <= faulted_next;
    end
  end

endmodule

FILE: dv/utf8_decode_checker.sv
`timescale 1ns / 100ps

module utf8_decode_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  u8d_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  u8d_pkg::out_t out_data,
  output int            mismatches,
  output int            pending
);

  // Decoder state as the byte stream leaves it.
  logic [7:0]  lead_byte;
  logic [20:0] gathered_bits;
  logic [1:0]  conts_left;
  logic [2:0]  seq_bytes;
  logic        discarding;

  u8d_pkg::out_t expected_points [$];
  u8d_pkg::out_t decoded;
  u8d_pkg::out_t oldest;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function void restart();
    lead_byte = '0;
    gathered_bits = '0;
    conts_left = '0;
    seq_bytes = '0;
  endfunction

  // An error drops the sequence; the rest of the buffer is skipped unless
  // the error came on its last byte.
  function u8d_pkg::out_t malformed(input logic last);
    restart();
    discarding = !last;
    malformed = '{code_point: '0, seq_length: '0, decode_error: 1'b1, at_buffer_end: last};
  endfunction

  function bit decode_byte(input u8d_pkg::in_t req, output u8d_pkg::out_t res);
    logic [7:0] b;
    logic       last;
    logic       bad;
    b = req.data_byte;
    last = req.buffer_last;
    res = '0;
    bad = 1'b0;
    if (discarding) begin
      if (last) begin
        discarding = 1'b0;
        restart();
      end
      return 1'b0;
    end
    if (conts_left == 2'd0) begin
      if (b < u8d_pkg::ASCII_LIMIT) begin
        res = '{code_point: {13'd0, b}, seq_length: u8d_pkg::LEN_ONE, decode_error: 1'b0,
                at_buffer_end: last};
        return 1'b1;
      end
      if (b < u8d_pkg::LEAD_MIN || b > u8d_pkg::LEAD_MAX) begin
        res = malformed(last);
        return 1'b1;
      end
      lead_byte = b;
      if (b < u8d_pkg::LEAD_THREE) begin
        seq_bytes = u8d_pkg::LEN_TWO;
        conts_left = 2'd1;
        gathered_bits = {16'd0, b[4:0]};
      end else if (b < u8d_pkg::LEAD_FOUR) begin
        seq_bytes = u8d_pkg::LEN_THREE;
        conts_left = 2'd2;
        gathered_bits = {17'd0, b[3:0]};
      end else begin
        seq_bytes = u8d_pkg::LEN_FOUR;
        conts_left = 2'd3;
        gathered_bits = {18'd0, b[2:0]};
      end
      if (last) begin
        res = malformed(last);
        return 1'b1;
      end
      return 1'b0;
    end
    if ((b & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_TAG) begin
      res = malformed(last);
      return 1'b1;
    end
    gathered_bits = {gathered_bits[14:0], b[5:0]};
    conts_left = conts_left - 2'd1;
    if (conts_left != 2'd0) begin
      if (last) begin
        res = malformed(last);
        return 1'b1;
      end
      return 1'b0;
    end
    if (seq_bytes == u8d_pkg::LEN_THREE) begin
      bad = gathered_bits < u8d_pkg::MIN_THREE ||
            (lead_byte == u8d_pkg::LEAD_SURROGATE &&
             gathered_bits >= u8d_pkg::SURROGATE_BASE);
    end else if (seq_bytes == u8d_pkg::LEN_FOUR) begin
      bad = gathered_bits < u8d_pkg::MIN_FOUR || gathered_bits > u8d_pkg::MAX_SCALAR;
    end
    if (bad) begin
      res = malformed(last);
      return 1'b1;
    end
    res = '{code_point: gathered_bits, seq_length: seq_bytes, decode_error: 1'b0,
            at_buffer_end: last};
    restart();
    return 1'b1;
  endfunction

  task report_field(input string field, input logic [20:0] want, input logic [20:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart();
      discarding = 1'b0;
      expected_points.delete();
    end else begin
      // Compare first: a result never leaves in the cycle its byte enters.
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: code_point %0h, seq_length %0d, decode_error %0b",
                 out_data.code_point, out_data.seq_length, out_data.decode_error);
          mismatches++;
        end else begin
          oldest = expected_points.pop_front();
          report_field("code_point", oldest.code_point, out_data.code_point);
          report_field("seq_length", 21'(oldest.seq_length), 21'(out_data.seq_length));
          report_field("decode_error", 21'(oldest.decode_error),
                       21'(out_data.decode_error));
          report_field("at_buffer_end", 21'(oldest.at_buffer_end),
                       21'(out_data.at_buffer_end));
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, decoded)) begin
          expected_points.push_back(decoded);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

FILE: dv/utf8_validating_decoder_test.sv
`timescale 1ns / 100ps

module utf8_validating_decoder_test;

  // Requests in the whole run, opening list included; the random stream
  // stops once this many requests have gone in.
  localparam int STREAM_BYTES = 1250;
  // After this many results the output side stops taking results for a long
  // stretch, so the decoder fills and pushes back on its input.
  localparam int HOLD_AFTER = 30;
  localparam int HOLD_CYCLES = 400;
  // The decoder keeps at most one result in flight, so a short
  // settling time at the end is enough to catch a stray one.
  localparam int SETTLE_CYCLES = 20;
  // Worst honest run: the random gaps on both sides for every byte plus the long hold.
  localparam int CYCLE_LIMIT = 200000;
  localparam int OPENING_BYTES = 29;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  u8d_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  u8d_pkg::out_t out_data;

  int mismatches;
  int pending;
  int cycle_count;
  int sent_count;
  bit send_calm;
  bit drain_calm;

  // Bytes of the character being built by the random generator.
  logic [7:0] char_bytes [$];

  // Opening list, each entry {byte, buffer_last}. It walks through the
  // shortest and longest forms and the lowest and highest scalar values,
  // then through many ways a buffer can go wrong: a stray continuation on
  // a buffer's last byte, a bad lead byte followed by skipped bytes, a lead
  // whose next byte is not a continuation (that byte must not start a new
  // sequence), a surrogate, an overlong three-byte form, a four-byte value
  // above the scalar range, and buffers that end on a lead byte and in the
  // middle of a sequence. A plain byte at the end shows the decoder is clean.
  logic [8:0] opening_bytes [OPENING_BYTES] = '{
    {8'h00, 1'b0},
    {8'hc2, 1'b0}, {8'h80, 1'b0},
    {8'he0, 1'b0}, {8'ha0, 1'b0}, {8'h80, 1'b0},
    {8'hf4, 1'b0}, {8'h8f, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b1},
    {8'h80, 1'b1},
    {8'hf5, 1'b0}, {8'h41, 1'b1},
    {8'hc2, 1'b0}, {8'h41, 1'b1},
    {8'hed, 1'b0}, {8'ha0, 1'b0}, {8'h80, 1'b1},
    {8'he0, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b1},
    {8'hf4, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b1},
    {8'he2, 1'b1},
    {8'hf0, 1'b0}, {8'h90, 1'b1},
    {8'h7f, 1'b0}
  };

  utf8_validating_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  utf8_decode_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a lost result ends up here.
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after it is taken.
  // The wait before each request is a random gap, except in calm
  // stretches where requests go back to back; the mode flips now and then.
  // When there is no wait, valid simply stays high with the new byte.
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      send_calm = !send_calm;
    end
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{data_byte: b, buffer_last: last};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Appends the UTF-8 form of a scalar value to the character under
  // construction. Surrogates are encoded like any other value, which the
  // decoder has to reject.
  function automatic void encode_scalar(input logic [20:0] cp);
    if (cp < 21'h80) begin
      char_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      char_bytes.push_back({3'b110, cp[10:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      char_bytes.push_back({4'b1110, cp[15:12]});
      char_bytes.push_back({2'b10, cp[11:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      char_bytes.push_back({5'b11110, cp[20:18]});
      char_bytes.push_back({2'b10, cp[17:12]});
      char_bytes.push_back({2'b10, cp[11:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // One character of the random stream. Most are well-formed characters of
  // every length; the rest are raw bytes, sequences cut off by the end of a
  // buffer, raw leads with arbitrary continuations (which land on overlong
  // forms, surrogates and out-of-range values), and sequences with one
  // continuation replaced by an arbitrary byte. A buffer usually ends on a
  // character boundary.
  task send_char();
    int         kind;
    int         cut;
    int         idx;
    logic       end_buf;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    end_buf = ($urandom_range(0, 7) == 0);
    char_bytes.delete();
    if (kind < 30) begin
      encode_scalar(21'($urandom_range(0, 21'h7f)));
    end else if (kind < 48) begin
      encode_scalar(21'($urandom_range(21'h80, 21'h7ff)));
    end else if (kind < 66) begin
      encode_scalar(21'($urandom_range(21'h800, 21'hffff)));
    end else if (kind < 82) begin
      encode_scalar(21'($urandom_range(21'h10000, 21'h10ffff)));
    end else if (kind < 87) begin
      char_bytes.push_back(8'($urandom_range(0, 255)));
      end_buf = ($urandom_range(0, 3) == 0);
    end else if (kind < 91) begin
      encode_scalar(21'($urandom_range(21'h80, 21'h10ffff)));
      cut = $urandom_range(1, char_bytes.size() - 1);
      while (char_bytes.size() > cut) void'(char_bytes.pop_back());
      end_buf = 1'b1;
    end else if (kind < 96) begin
      lead = 8'($urandom_range(u8d_pkg::LEAD_THREE, u8d_pkg::LEAD_MAX));
      char_bytes.push_back(lead);
      repeat ((lead < u8d_pkg::LEAD_FOUR) ? 2 : 3) begin
        char_bytes.push_back(u8d_pkg::CONT_TAG | 8'($urandom_range(0, 63)));
      end
    end else begin
      encode_scalar(21'($urandom_range(21'h80, 21'h10ffff)));
      idx = $urandom_range(1, char_bytes.size() - 1);
      char_bytes[idx] = 8'($urandom_range(0, 255));
    end
    foreach (char_bytes[i]) begin
      send_byte(char_bytes[i], end_buf && (i == char_bytes.size() - 1));
    end
  endtask

  // Output side: holds off before each result by a drawn number of cycles,
  // with calm stretches of no holding, and once stops for a long stretch
  // while the input side keeps offering requests.
  initial begin : drain
    int gap;
    int taken;
    out_ready = 1'b0;
    drain_calm = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_AFTER) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) begin
          drain_calm = !drain_calm;
        end
        gap = drain_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_calm = 1'b0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_bytes[i]) begin
      send_byte(opening_bytes[i][8:1], opening_bytes[i][0]);
    end
    // Close whatever buffer the opening left open so the random stream
    // starts from a clean decoder state either way.
    send_byte(8'h20, 1'b1);

    while (sent_count < STREAM_BYTES) send_char();
    in_valid = 1'b0;

    // Wait for every predicted result, then a little longer for strays.
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/utf8_validating_decoder.sv
dv/utf8_decode_checker.sv
dv/utf8_validating_decoder_test.sv
